/* rtl/wbb_pkg.sv */
// wbb_pkg: shared types, constants and helper functions for the weighted box blur
// no dependencies; used by wbb_seq, wbb_front, wbb_mac, wbb_chk and the top level
`default_nettype none

package wbb_pkg;

    // default sizing of the top level
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_KERNEL   = 7;

    // largest window the datapath is built for; the line word is padded to this
    localparam int KMAX       = 7;
    localparam int LINE_MAX_W = 8 * (KMAX - 1);

    // register map of the configuration port
    localparam logic [1:0] CFG_KERNEL   = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_CHANNELS = 2'd2;
    localparam int         CFG_DATA_W   = 11;

    localparam logic [1:0]  RST_KERNEL   = 2'd0;
    localparam logic [10:0] RST_WIDTH    = 11'd1024;
    localparam logic [2:0]  RST_CHANNELS = 3'd3;

    // window size codes
    localparam logic [1:0] K3 = 2'd0;
    localparam logic [1:0] K5 = 2'd1;
    localparam logic [1:0] K7 = 2'd2;

    localparam int SUM_W = 14;  // 49 bytes
    localparam int ACC_W = 20;

    typedef struct packed {
        logic [7:0] sample;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  blurred;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic [1:0]  out_channel;
    } t_out_item;

    // per item control travelling down the pipe
    typedef struct packed {
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic [1:0]  out_channel;
        logic        produce;
        logic [1:0]  kc;
    } t_tag;

    // summary of one column vector: partial sums and the possible centre bytes
    typedef struct packed {
        logic [9:0]  s3;
        logic [10:0] s5;
        logic [10:0] s7;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
    } t_colsum;

    function automatic logic [3:0] k_size(input logic [1:0] kc);
        case (kc)
            K3:      k_size = 4'd3;
            K5:      k_size = 4'd5;
            default: k_size = 4'd7;
        endcase
    endfunction

    function automatic logic [10:0] col_pick(input t_colsum c, input logic [1:0] kc);
        case (kc)
            K3:      col_pick = 11'(c.s3);
            K5:      col_pick = c.s5;
            default: col_pick = c.s7;
        endcase
    endfunction

    function automatic logic [7:0] centre_pick(input t_colsum c, input logic [1:0] kc);
        case (kc)
            K3:      centre_pick = c.c1;
            K5:      centre_pick = c.c2;
            default: centre_pick = c.c3;
        endcase
    endfunction

    function automatic logic [4:0] w_sum(input logic [1:0] kc);
        case (kc)
            K3:      w_sum = 5'd28;
            K5:      w_sum = 5'd10;
            default: w_sum = 5'd5;
        endcase
    endfunction

    function automatic logic [3:0] w_centre(input logic [1:0] kc);
        case (kc)
            K3:      w_centre = 4'd3;
            K5:      w_centre = 4'd5;
            default: w_centre = 4'd10;
        endcase
    endfunction

endpackage

`default_nettype wire

/* rtl/wbb_stream_if.sv */
// wbb_stream_if: valid/ready stream channel with a typed payload
// no dependencies; payload types come from wbb_pkg at instantiation
`default_nettype none

interface wbb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/wbb_ram.sv */
// wbb_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module wbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

/* rtl/wbb_seq.sv */
// wbb_seq: configuration registers and raster position counters
// depends on wbb_pkg
`default_nettype none

module wbb_seq #(
    parameter int MAX_WIDTH    = wbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = wbb_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = wbb_pkg::DEF_MAX_KERNEL,
    parameter int XW  = $clog2(MAX_WIDTH),
    parameter int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int SW  = $clog2(MAX_KERNEL)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_idx,
    input  wire logic [wbb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_acc,
    input  wire logic                              i_frame_start,
    output wbb_pkg::t_tag                          o_tag,
    output logic      [CHW-1:0]                    o_ch,
    output logic      [SW-1:0]                     o_slot,
    output logic      [XW+CHW-1:0]                 o_addr
);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > 11) ? WW : 11;

    logic [1:0]     r_ksel;
    logic [10:0]    r_width;
    logic [2:0]     r_nch;
    logic [CHW-1:0] r_ch, ch0;
    logic [XW-1:0]  r_x, x0;
    logic [SW-1:0]  r_slot, slot0;
    logic [11:0]    r_row, row0;
    logic [1:0]     kc;
    logic [3:0]     km1;
    logic [CMPW-1:0] w_eff, x_inc;
    logic [2:0]     nch_eff, ch_inc;

    always_comb begin
        ch0   = i_frame_start ? '0 : r_ch;
        x0    = i_frame_start ? '0 : r_x;
        slot0 = i_frame_start ? '0 : r_slot;
        row0  = i_frame_start ? '0 : r_row;

        case (r_ksel)
            wbb_pkg::K3: kc = wbb_pkg::K3;
            wbb_pkg::K5: kc = wbb_pkg::K5;
            default:     kc = wbb_pkg::K7;
        endcase
        if (kc == wbb_pkg::K7 && MAX_KERNEL < 7) begin
            kc = (MAX_KERNEL >= 5) ? wbb_pkg::K5 : wbb_pkg::K3;
        end
        if (kc == wbb_pkg::K5 && MAX_KERNEL < 5) begin
            kc = wbb_pkg::K3;
        end
        km1 = wbb_pkg::k_size(kc) - 4'd1;

        if (r_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_width);
        end
        x_inc = CMPW'(x0) + CMPW'(1);

        if (r_nch == '0) begin
            nch_eff = 3'd1;
        end else if (r_nch > 3'(MAX_CHANNELS)) begin
            nch_eff = 3'(MAX_CHANNELS);
        end else begin
            nch_eff = r_nch;
        end
        ch_inc = 3'(ch0) + 3'd1;

        o_tag.produce     = (row0 >= 12'(km1)) && (CMPW'(x0) >= CMPW'(km1));
        o_tag.out_row     = row0 - 12'(km1);
        o_tag.out_col     = 10'(CMPW'(x0) - CMPW'(km1));
        o_tag.out_channel = 2'(ch0);
        o_tag.kc          = kc;
        o_ch   = ch0;
        o_slot = slot0;
        o_addr = {x0, ch0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksel  <= wbb_pkg::RST_KERNEL;
            r_width <= wbb_pkg::RST_WIDTH;
            r_nch   <= wbb_pkg::RST_CHANNELS;
            r_ch    <= '0;
            r_x     <= '0;
            r_slot  <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wbb_pkg::CFG_KERNEL:   r_ksel  <= i_cfg_data[1:0];
                    wbb_pkg::CFG_WIDTH:    r_width <= i_cfg_data[10:0];
                    wbb_pkg::CFG_CHANNELS: r_nch   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_acc) begin
                if (ch_inc >= nch_eff) begin
                    r_ch <= '0;
                    if (x_inc >= w_eff) begin
                        r_x    <= '0;
                        r_slot <= '0;
                        r_row  <= row0 + 12'd1;
                    end else begin
                        r_x    <= XW'(x_inc);
                        r_slot <= (slot0 == SW'(MAX_KERNEL - 1)) ? '0 : slot0 + SW'(1);
                        r_row  <= row0;
                    end
                end else begin
                    r_ch   <= CHW'(ch_inc);
                    r_x    <= x0;
                    r_slot <= slot0;
                    r_row  <= row0;
                end
            end
        end
    end
endmodule

`default_nettype wire

/* rtl/wbb_front.sv */
// wbb_front: line store, column vector build, window column summaries, partial window sum
// depends on wbb_pkg and wbb_ram
`default_nettype none

module wbb_front #(
    parameter int MAX_WIDTH    = wbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = wbb_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = wbb_pkg::DEF_MAX_KERNEL,
    parameter int XW  = $clog2(MAX_WIDTH),
    parameter int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int SW  = $clog2(MAX_KERNEL)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_acc,
    input  wire logic [7:0]                  i_sample,
    input  wbb_pkg::t_tag                    i_tag,
    input  wire logic [CHW-1:0]              i_ch,
    input  wire logic [SW-1:0]               i_slot,
    input  wire logic [XW+CHW-1:0]           i_addr,
    input  wire logic                        i_s2_free,
    output logic                             o_busy,
    output logic                             o_go,
    output logic                             o_load,
    output logic      [wbb_pkg::SUM_W-1:0]   o_part,
    output logic      [10:0]                 o_cur,
    output logic      [7:0]                  o_centre,
    output wbb_pkg::t_tag                    o_tag
);
    localparam int LW    = 8 * (MAX_KERNEL - 1);
    localparam int DEPTH = MAX_WIDTH * (2 ** CHW);

    logic                r_v;
    wbb_pkg::t_tag       r_tag;
    logic [7:0]          r_sample;
    logic [CHW-1:0]      r_ch;
    logic [SW-1:0]       r_slot;
    logic [XW+CHW-1:0]   r_addr;
    logic                r_byp;
    logic [LW-1:0]       r_byp_word;
    logic [LW-1:0]       ram_rdata, l_word, n_word;
    logic [wbb_pkg::LINE_MAX_W-1:0] lx;
    logic [7:0]          v [wbb_pkg::KMAX];
    wbb_pkg::t_colsum    n_col;
    wbb_pkg::t_colsum    r_win [MAX_CHANNELS][MAX_KERNEL];
    logic [wbb_pkg::SUM_W-1:0] part;
    logic [3:0]          d, kval, mid, cs;
    logic                go;

    assign go     = r_v && (i_s2_free || !r_tag.produce);
    assign o_busy = r_v;
    assign o_go   = go;
    assign o_load = go && r_tag.produce;

    wbb_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_line (
        .i_clk  (i_clk),
        .i_we   (go),
        .i_waddr(r_addr),
        .i_wdata(n_word),
        .i_re   (i_acc),
        .i_raddr(i_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        // newest row in the low byte, oldest kept row at the top
        l_word = r_byp ? r_byp_word : ram_rdata;
        n_word = {l_word[LW-9:0], r_sample};
        lx     = wbb_pkg::LINE_MAX_W'(l_word);
        v[0]   = r_sample;
        for (int i = 1; i < wbb_pkg::KMAX; i++) begin
            v[i] = lx[8*(i-1) +: 8];
        end
        n_col.s3 = 10'(v[0]) + 10'(v[1]) + 10'(v[2]);
        n_col.s5 = 11'(n_col.s3) + 11'(v[3]) + 11'(v[4]);
        n_col.s7 = n_col.s5 + 11'(v[5]) + 11'(v[6]);
        n_col.c1 = v[1];
        n_col.c2 = v[2];
        n_col.c3 = v[3];
    end

    // sum of the older columns of the window, and the slot of the centre column
    always_comb begin
        kval = wbb_pkg::k_size(r_tag.kc);
        mid  = kval >> 1;
        part = '0;
        d    = '0;
        for (int s = 0; s < MAX_KERNEL; s++) begin
            if (SW'(s) != r_slot) begin
                d = (4'(r_slot) >= 4'(s)) ? 4'(r_slot) - 4'(s)
                                          : 4'(r_slot) + 4'(MAX_KERNEL) - 4'(s);
                if (d < kval) begin
                    part = part + wbb_pkg::SUM_W'(wbb_pkg::col_pick(r_win[r_ch][s], r_tag.kc));
                end
            end
        end
        cs = (4'(r_slot) >= mid) ? 4'(r_slot) - mid : 4'(r_slot) + 4'(MAX_KERNEL) - mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_byp <= 1'b0;
        end else begin
            if (i_acc) begin
                r_v <= 1'b1;
            end else if (go) begin
                r_v <= 1'b0;
            end
            if (i_acc) begin
                r_byp <= r_v && go && (i_addr == r_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_tag      <= i_tag;
            r_sample   <= i_sample;
            r_ch       <= i_ch;
            r_slot     <= i_slot;
            r_addr     <= i_addr;
            r_byp_word <= n_word;
        end
        if (go) begin
            r_win[r_ch][r_slot] <= n_col;
        end
    end

    assign o_part   = part;
    assign o_cur    = wbb_pkg::col_pick(n_col, r_tag.kc);
    assign o_centre = wbb_pkg::centre_pick(r_win[r_ch][SW'(cs)], r_tag.kc);
    assign o_tag    = r_tag;
endmodule

`default_nettype wire

/* rtl/wbb_mac.sv */
// wbb_mac: final window sum, weighting and the output register
// depends on wbb_pkg
`default_nettype none

module wbb_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic [wbb_pkg::SUM_W-1:0]   i_part,
    input  wire logic [10:0]                 i_cur,
    input  wire logic [7:0]                  i_centre,
    input  wbb_pkg::t_tag                    i_tag,
    input  wire logic                        i_out_ready,
    output logic                             o_s2_free,
    output logic                             o_out_valid,
    output wbb_pkg::t_out_item               o_out
);
    logic                      r2_v, r_ov;
    logic [wbb_pkg::SUM_W-1:0] r2_part;
    logic [10:0]               r2_cur;
    logic [7:0]                r2_centre;
    wbb_pkg::t_tag             r2_tag;
    wbb_pkg::t_out_item        r_out;
    logic [wbb_pkg::SUM_W-1:0] sum;
    logic [wbb_pkg::ACC_W-1:0] acc;
    logic                      out_free, s2_go;

    assign out_free  = !r_ov || i_out_ready;
    assign s2_go     = r2_v && out_free;
    assign o_s2_free = !r2_v || out_free;

    always_comb begin
        sum = r2_part + wbb_pkg::SUM_W'(r2_cur);
        acc = wbb_pkg::ACC_W'(sum) * wbb_pkg::ACC_W'(wbb_pkg::w_sum(r2_tag.kc))
            + wbb_pkg::ACC_W'(r2_centre) * wbb_pkg::ACC_W'(wbb_pkg::w_centre(r2_tag.kc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_load) begin
                r2_v <= 1'b1;
            end else if (s2_go) begin
                r2_v <= 1'b0;
            end
            if (s2_go) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r2_part   <= i_part;
            r2_cur    <= i_cur;
            r2_centre <= i_centre;
            r2_tag    <= i_tag;
        end
        if (s2_go) begin
            r_out.blurred     <= acc[15:8];
            r_out.out_row     <= r2_tag.out_row;
            r_out.out_col     <= r2_tag.out_col;
            r_out.out_channel <= r2_tag.out_channel;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;
endmodule

`default_nettype wire

/* rtl/weighted_box_blur_filter.sv */
// weighted_box_blur_filter: 3x3 / 5x5 / 7x7 weighted box blur over an interleaved raster stream
// results pass the stage 1, stage 2 and output registers; throughput one item per cycle while
// the output is not stalled, set by the line store ram (one read and one write per cycle); up to
// three items buffer behind a stalled output. synchronous active low reset clears counters, valids
// and config to 3x3, width 1024, three channels; line and window stores are not cleared
`default_nettype none

module weighted_box_blur_filter #(
    parameter int MAX_WIDTH    = wbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = wbb_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = wbb_pkg::DEF_MAX_KERNEL
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_idx,
    input  wire logic [wbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wbb_stream_if.sink                          i_pix,
    wbb_stream_if.source                        o_blur
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW  = $clog2(MAX_KERNEL);

    logic                      acc;
    wbb_pkg::t_tag             s0_tag, s1_tag;
    logic [CHW-1:0]            s0_ch;
    logic [SW-1:0]             s0_slot;
    logic [XW+CHW-1:0]         s0_addr;
    logic                      s1_busy, s1_go, s1_load, s2_free;
    logic [wbb_pkg::SUM_W-1:0] s1_part;
    logic [10:0]               s1_cur;
    logic [7:0]                s1_centre;
    wbb_pkg::t_in_item         pix;

    // the first stage is free or leaves this cycle: take the next transfer
    assign pix         = i_pix.data;
    assign i_pix.ready = !s1_busy || s1_go;
    assign acc         = i_pix.valid && i_pix.ready;

    // position counters and config registers; frame start zeroes positions before use
    wbb_seq #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL),
        .XW(XW), .CHW(CHW), .SW(SW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_acc        (acc),
        .i_frame_start(pix.frame_start),
        .o_tag        (s0_tag),
        .o_ch         (s0_ch),
        .o_slot       (s0_slot),
        .o_addr       (s0_addr)
    );

    // stage 1: line store read returns, column is built, window state written,
    // older window columns summed
    wbb_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL),
        .XW(XW), .CHW(CHW), .SW(SW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_sample (pix.sample),
        .i_tag    (s0_tag),
        .i_ch     (s0_ch),
        .i_slot   (s0_slot),
        .i_addr   (s0_addr),
        .i_s2_free(s2_free),
        .o_busy   (s1_busy),
        .o_go     (s1_go),
        .o_load   (s1_load),
        .o_part   (s1_part),
        .o_cur    (s1_cur),
        .o_centre (s1_centre),
        .o_tag    (s1_tag)
    );

    // stage 2: weighting into the output register; only complete windows get here
    wbb_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_load),
        .i_part     (s1_part),
        .i_cur      (s1_cur),
        .i_centre   (s1_centre),
        .i_tag      (s1_tag),
        .i_out_ready(o_blur.ready),
        .o_s2_free  (s2_free),
        .o_out_valid(o_blur.valid),
        .o_out      (o_blur.data)
    );
endmodule

`default_nettype wire

/* rtl/wbb_chk.sv */
// wbb_chk: port level checks for weighted_box_blur_filter, bound to the top level
// depends on wbb_pkg
`default_nettype none

module wbb_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wbb_pkg::t_out_item      i_out_data
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // with the output register empty the pipe always drains, so input is taken
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused with empty output");

    // no result can appear without an earlier input transfer
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) && $past(i_rst_n, 3) |-> $past(i_in_valid && i_in_ready, 3)
            || $past(i_in_valid && i_in_ready, 4) || $past(!i_in_ready, 1))
        else $error("result without input");
endmodule

bind weighted_box_blur_filter wbb_chk u_wbb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pix.valid),
    .i_in_ready (i_pix.ready),
    .i_out_valid(o_blur.valid),
    .i_out_ready(o_blur.ready),
    .i_out_data (o_blur.data)
);

`default_nettype wire
